[design/assert_macros.svh]
// Assertion macros for the design files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SEE_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define SEE_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SEE_ASSERT(label, clk, rstn, prop)
`define SEE_ASSERT_RST(label, clk, prop)
`endif
`endif

[design/see_pkg.sv]
// Package of the silhouette edge extruder: commands, widths, sizes.
`timescale 1ns / 1ps
package see_pkg;
  localparam int unsigned VertexDepth = 1024;
  localparam int unsigned FaceDepth   = 1024;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned NeighW      = 11;
  localparam int unsigned ScaleW      = 16;
  localparam int unsigned CfgAddrW    = 2;

  localparam logic [1:0] CmdLoadVert = 2'd0;
  localparam logic [1:0] CmdLoadFace = 2'd1;
  localparam logic [1:0] CmdExtrude  = 2'd2;

  localparam logic [CfgAddrW-1:0] RegLightX = 2'd0;
  localparam logic [CfgAddrW-1:0] RegLightY = 2'd1;
  localparam logic [CfgAddrW-1:0] RegLightZ = 2'd2;
  localparam logic [CfgAddrW-1:0] RegScale  = 2'd3;

  typedef struct packed {
    logic [IdxW-1:0] c0, c1, c2;
    logic [NeighW-1:0] n0, n1, n2;
  } face_t;
endpackage

[design/silhouette_edge_extruder.sv]
// Top level of the silhouette edge extruder: tables, sequencer, output register.
//
// Usage: one request channel (cmd_i ... neigh_2_i, valid_i / stall_o) takes
// vertex loads, face loads and extrude commands; one result channel
// (near/far coordinates, second_end_o, has_edge_o, last_o, valid_o / stall_i)
// returns endpoints. Set light and scale through the write port while idle;
// set the light before faces load, since visibility is fixed at load time.
// One request is handled at a time. A vertex load is written when accepted;
// a face load runs multiply, sum, then write of the record with its visible
// bit. An extrude reads the face record, checks the three neighbour records
// one after another, then per endpoint reads the vertex memory and runs the
// far-point pipeline; each memory has a single read port. A face with no
// silhouette edge gives one empty result with last set. The result register
// holds while stall_i is high and the sequencer waits. Reset clears control
// state only; memory contents are undefined until written.
`timescale 1ns / 1ps
module silhouette_edge_extruder import see_pkg::*; #(
  parameter int unsigned VERTEX_DEPTH = VertexDepth,
  parameter int unsigned FACE_DEPTH   = FaceDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]   cfg_data_i,
  input  logic valid_i,
  output logic stall_o,
  input  logic [1:0]               cmd_i,
  input  logic [IdxW-1:0]          index_i,
  input  logic signed [CoordW-1:0] val_a_i, val_b_i, val_c_i, val_d_i,
  input  logic [IdxW-1:0]          vert_0_i, vert_1_i, vert_2_i,
  input  logic signed [NeighW-1:0] neigh_0_i, neigh_1_i, neigh_2_i,
  output logic valid_o,
  input  logic stall_i,
  output logic signed [CoordW-1:0] near_x_o, near_y_o, near_z_o,
  output logic signed [CoordW-1:0] far_x_o, far_y_o, far_z_o,
  output logic second_end_o,
  output logic has_edge_o,
  output logic last_o
);
`include "assert_macros.svh"
  localparam int unsigned VAW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int unsigned FAW = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_VIS1, S_VIS2, S_VIS3, S_FRD, S_NRD, S_NCHK, S_EDGE, S_VRD, S_F1,
    S_F2, S_OUT, S_EMPTY
  } state_e;

  typedef struct packed {
    face_t rec;
    logic  vis;
  } frec_t;

  // Configuration registers.
  logic signed [CoordW-1:0] lx_q, ly_q, lz_q;
  logic [ScaleW-1:0] scale_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q <= '0; ly_q <= '0; lz_q <= '0; scale_q <= ScaleW'(100);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLightX: lx_q <= cfg_data_i;
        RegLightY: ly_q <= cfg_data_i;
        RegLightZ: lz_q <= cfg_data_i;
        RegScale:  scale_q <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Memories: vertex table and face record table with its visible bit.
  logic [3*CoordW-1:0] vmem [VERTEX_DEPTH];
  frec_t               fmem [FACE_DEPTH];

  state_e state_q;
  logic [IdxW-1:0] idx_q;
  logic signed [CoordW-1:0] a_q, b_q, c_q, d_q;
  face_t rec_q;
  logic [1:0] k_q;          // neighbour / edge number
  logic [2:0] sil_q;        // silhouette flag per edge
  logic fvis_q;
  logic second_q, any_q;
  logic [3*CoordW-1:0] vrd_q;
  frec_t frd_q;
  logic vis_w;
  logic signed [CoordW-1:0] fx_w, fy_w, fz_w;
  logic vinr_q;

  see_vis u_vis (.clk_i, .a_i(a_q), .b_i(b_q), .c_i(c_q), .d_i(d_q),
    .lx_i(lx_q), .ly_i(ly_q), .lz_i(lz_q), .vis_o(vis_w));

  logic signed [CoordW-1:0] vx, vy, vz;
  assign vx = vinr_q ? vrd_q[3*CoordW-1:2*CoordW] : '0;
  assign vy = vinr_q ? vrd_q[2*CoordW-1:CoordW] : '0;
  assign vz = vinr_q ? vrd_q[CoordW-1:0] : '0;
  see_far u_fx (.clk_i, .v_i(vx), .l_i(lx_q), .scale_i(scale_q), .far_o(fx_w));
  see_far u_fy (.clk_i, .v_i(vy), .l_i(ly_q), .scale_i(scale_q), .far_o(fy_w));
  see_far u_fz (.clk_i, .v_i(vz), .l_i(lz_q), .scale_i(scale_q), .far_o(fz_w));

  // Memory read address selection.
  logic [IdxW-1:0] nb_sel_w, vsel_w;
  logic signed [NeighW-1:0] nb_w;
  always_comb begin
    case (k_q)
      2'd0: nb_w = rec_q.n0;
      2'd1: nb_w = rec_q.n1;
      default: nb_w = rec_q.n2;
    endcase
    nb_sel_w = nb_w[IdxW-1:0];
    case ({k_q, second_q})
      3'b000: vsel_w = rec_q.c0;
      3'b001: vsel_w = rec_q.c1;
      3'b010: vsel_w = rec_q.c1;
      3'b011: vsel_w = rec_q.c2;
      3'b100: vsel_w = rec_q.c2;
      default: vsel_w = rec_q.c0;
    endcase
  end

  logic fire_in, fire_out, out_load;
  assign fire_in  = valid_i && !stall_o;
  assign fire_out = valid_o && !stall_i;
  assign stall_o  = (state_q != S_IDLE) || valid_o;
  // The result register takes a new value in this cycle.
  assign out_load = (state_q == S_OUT || state_q == S_EMPTY) && (!valid_o || fire_out);

  logic face_ok, vert_ok;
  assign face_ok = 32'(index_i) < FACE_DEPTH;
  assign vert_ok = 32'(index_i) < VERTEX_DEPTH;

  // Memory writes and reads. The face record is written once its visible
  // bit is known.
  always_ff @(posedge clk_i) begin
    if (fire_in && cmd_i == CmdLoadVert && vert_ok)
      vmem[index_i[VAW-1:0]] <= {val_a_i, val_b_i, val_c_i};
    if (state_q == S_VIS3)
      fmem[idx_q[FAW-1:0]] <= '{rec_q, vis_w};
    frd_q <= fmem[(state_q == S_IDLE || state_q == S_FRD) ? idx_q[FAW-1:0]
                                                          : nb_sel_w[FAW-1:0]];
    vrd_q <= vmem[vsel_w[VAW-1:0]];
  end

  logic nb_ok;
  assign nb_ok = !nb_w[NeighW-1] && (32'(nb_w[IdxW-1:0]) < FACE_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_o <= 1'b0;
      k_q <= '0; second_q <= 1'b0; any_q <= 1'b0; sil_q <= '0; fvis_q <= 1'b0;
      vinr_q <= 1'b0;
    end else begin
      if (fire_out && !out_load) valid_o <= 1'b0;
      case (state_q)
        S_IDLE: if (fire_in) begin
          idx_q <= index_i;
          a_q <= val_a_i; b_q <= val_b_i; c_q <= val_c_i; d_q <= val_d_i;
          rec_q <= '{vert_0_i, vert_1_i, vert_2_i, neigh_0_i, neigh_1_i, neigh_2_i};
          if (cmd_i == CmdLoadFace && face_ok) state_q <= S_VIS1;
          else if (cmd_i == CmdExtrude) state_q <= face_ok ? S_FRD : S_EMPTY;
        end
        S_VIS1: state_q <= S_VIS2;  // products are being registered
        S_VIS2: state_q <= S_VIS3;  // sum and compare are being registered
        S_VIS3: state_q <= S_IDLE;  // record and visible bit are written
        S_FRD: state_q <= S_NRD;   // wait for registered reads of the face
        S_NRD: begin
          rec_q <= frd_q.rec; fvis_q <= frd_q.vis; k_q <= '0; sil_q <= '0;
          state_q <= S_NCHK;
        end
        S_NCHK: state_q <= S_EDGE;  // neighbour record is being read
        S_EDGE: begin
          // frd_q holds the neighbour record for edge k_q
          sil_q[k_q] <= !nb_ok || !frd_q.vis;
          if (k_q == 2'd2) begin
            k_q <= '0; second_q <= 1'b0; any_q <= 1'b0;
            state_q <= fvis_q ? S_VRD : S_EMPTY;
          end else begin
            k_q <= k_q + 2'd1;
            state_q <= S_NCHK;
          end
        end
        S_VRD: begin
          if (k_q == 2'd3) begin
            state_q <= any_q ? S_IDLE : S_EMPTY;
          end else if (!sil_q[k_q]) begin
            k_q <= k_q + 2'd1;
          end else begin
            vinr_q <= 32'(vsel_w) < VERTEX_DEPTH;
            state_q <= S_F1;
          end
        end
        S_F1: state_q <= S_F2;
        S_F2: state_q <= S_OUT;
        S_OUT: if (out_load) begin
          near_x_o <= vx; near_y_o <= vy; near_z_o <= vz;
          far_x_o <= fx_w; far_y_o <= fy_w; far_z_o <= fz_w;
          second_end_o <= second_q; has_edge_o <= 1'b1;
          last_o <= second_q && (k_q == 2'd2 ||
                    (k_q == 2'd1 && !sil_q[2]) ||
                    (k_q == 2'd0 && !sil_q[1] && !sil_q[2]));
          valid_o <= 1'b1;
          any_q <= 1'b1;
          if (second_q) begin
            second_q <= 1'b0; k_q <= k_q + 2'd1;
          end else begin
            second_q <= 1'b1;
          end
          state_q <= S_VRD;
        end
        S_EMPTY: if (out_load) begin
          near_x_o <= '0; near_y_o <= '0; near_z_o <= '0;
          far_x_o <= '0; far_y_o <= '0; far_z_o <= '0;
          second_end_o <= 1'b0; has_edge_o <= 1'b0; last_o <= 1'b1;
          valid_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The vertex read is issued in S_VRD; its data stays put in vrd_q because
  // the address holds until S_OUT moves on to the next endpoint.

  `SEE_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != S_IDLE) |-> !fire_in)
  `SEE_ASSERT(a_empty_last, clk_i, rst_ni, (valid_o && !has_edge_o) |-> last_o)
  `SEE_ASSERT(a_second_has_edge, clk_i, rst_ni, (valid_o && second_end_o) |-> has_edge_o)
endmodule

[design/see_far.sv]
// Far point unit: v + (v - l) * scale, saturated, two register stages.
`timescale 1ns / 1ps
module see_far import see_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [CoordW-1:0] v_i,
  input  logic signed [CoordW-1:0] l_i,
  input  logic        [ScaleW-1:0] scale_i,
  output logic signed [CoordW-1:0] far_o
);
  logic signed [CoordW:0] diff_q, diff_d;
  logic signed [CoordW-1:0] v_q;
  logic signed [CoordW+ScaleW+1:0] prod, sum;
  assign diff_d = {v_i[CoordW-1], v_i} - {l_i[CoordW-1], l_i};
  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    v_q <= v_i;
  end
  assign prod = diff_q * $signed({1'b0, scale_i});
  assign sum = prod + {{(ScaleW+2){v_q[CoordW-1]}}, v_q};
  always_ff @(posedge clk_i) begin
    if (sum > $signed({{(ScaleW+2){1'b0}}, 1'b0, {(CoordW-1){1'b1}}}))
      far_o <= {1'b0, {(CoordW-1){1'b1}}};
    else if (sum < $signed({{(ScaleW+2){1'b1}}, 1'b1, {(CoordW-1){1'b0}}}))
      far_o <= {1'b1, {(CoordW-1){1'b0}}};
    else
      far_o <= sum[CoordW-1:0];
  end
endmodule

[design/see_vis.sv]
// Plane-against-light visibility, two register stages.
`timescale 1ns / 1ps
module see_vis import see_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [CoordW-1:0] a_i, b_i, c_i, d_i,
  input  logic signed [CoordW-1:0] lx_i, ly_i, lz_i,
  output logic                     vis_o
);
  logic signed [2*CoordW-1:0] pa_q, pb_q, pc_q;
  logic signed [CoordW-1:0] d_q;
  logic signed [2*CoordW+1:0] tot;
  always_ff @(posedge clk_i) begin
    pa_q <= a_i * lx_i;
    pb_q <= b_i * ly_i;
    pc_q <= c_i * lz_i;
    d_q  <= d_i;
  end
  assign tot = 66'(pa_q) + 66'(pb_q) + 66'(pc_q) + {{18{d_q[CoordW-1]}}, d_q, 16'd0};
  always_ff @(posedge clk_i) vis_o <= (tot > 66'sd0);
endmodule
